// File: hdl/tcc_pkg.sv
// Package for the timestamp clock converter.
// Holds register indexes, function and mode codes, and the divider cell payload type.
// No dependencies.
package tcc_pkg;

	localparam int unsigned DIV_STEPS = 95;
	localparam int unsigned QUO_W     = 95;
	localparam int unsigned TS_W      = 64;
	localparam int unsigned MULT_W    = 32;
	localparam int unsigned SHIFT_W   = 5;
	localparam int unsigned IDX_W     = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE        = 3'd0,
		REG_MULT        = 3'd1,
		REG_SHIFT       = 3'd2,
		REG_ZERO        = 3'd3,
		REG_OFFSET      = 3'd4,
		REG_FIX_EN      = 3'd5,
		REG_FIX_MULT    = 3'd6,
		REG_FIX_SHIFT   = 3'd7
	} reg_idx_t;

	localparam logic [1:0] FUNC_TO_EVENT = 2'd0;
	localparam logic [1:0] FUNC_TO_NS    = 2'd1;
	localparam logic [1:0] FUNC_TO_REAL  = 2'd2;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_TICKS = 2'd1;

	typedef struct packed {
		logic use_div;
		logic use_mul;
		logic fix_sel;
		logic add_off;
	} flags_t;

	typedef struct packed {
		flags_t              flags;
		logic [TS_W-1:0]     a;
		logic [TS_W-1:0]     x;
		logic [MULT_W-1:0]   rem;
		logic [QUO_W-1:0]    quo;
	} cell_t;

endpackage

// File: hdl/tcc_div_cell.sv
// One restoring division step of the divider chain.
// Depends on tcc_pkg.
module tcc_div_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [tcc_pkg::MULT_W-1:0]   divisor,
	input  logic                         valid_i,
	input  tcc_pkg::cell_t               d,
	output logic                         valid_o,
	output tcc_pkg::cell_t               q
);

	logic                       bit_in;
	logic [tcc_pkg::MULT_W:0]   cur;
	logic [tcc_pkg::MULT_W:0]   diff;
	logic                       ge;
	tcc_pkg::cell_t             nxt;
	logic                       valid_q;
	tcc_pkg::cell_t             data_q;

	generate
		if (INDEX < tcc_pkg::TS_W) begin : g_bit
			assign bit_in = d.x[tcc_pkg::TS_W-1-INDEX];
		end else begin : g_zero
			assign bit_in = 1'b0;
		end
	endgenerate

	always_comb begin
		cur  = {d.rem, bit_in};
		diff = cur - {1'b0, divisor};
		ge   = (cur >= {1'b0, divisor});
		nxt  = d;
		nxt.rem = ge ? diff[tcc_pkg::MULT_W-1:0] : cur[tcc_pkg::MULT_W-1:0];
		nxt.quo = {d.quo[tcc_pkg::QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign valid_o = valid_q;
	assign q       = data_q;

endmodule

// File: hdl/timestamp_clock_converter.sv
// Top level of the timestamp clock converter: registers, pre stage, divider chain,
// multiplier and final add. Depends on tcc_pkg and tcc_div_cell.
//
// channel  direction  handshake              payload
// in       to block   in_valid / in_stall    func, timestamp_in
// out      from block out_valid / out_stall  timestamp_out
// cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low; the pipeline is the pre stage,
// the chain of 95 division cells, then the quotient select, multiply, shift and add stages.
// Reset clears all valid bits and sets the registers to their defaults.
// A stalled output freezes the whole pipeline; in_stall is high exactly then.
module timestamp_clock_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [tcc_pkg::TS_W-1:0]      timestamp_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tcc_pkg::TS_W-1:0]      timestamp_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [tcc_pkg::TS_W-1:0]      cfg_data
);

	logic [1:0]                     mode_q;
	logic [tcc_pkg::MULT_W-1:0]     mult_q;
	logic [tcc_pkg::SHIFT_W-1:0]    shift_q;
	logic [tcc_pkg::TS_W-1:0]       zero_q;
	logic [tcc_pkg::TS_W-1:0]       offset_q;
	logic                           fix_en_q;
	logic [tcc_pkg::MULT_W-1:0]     fix_mult_q;
	logic [tcc_pkg::SHIFT_W-1:0]    fix_shift_q;

	logic                           en;
	logic                           cfg_we;

	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= tcc_pkg::MODE_NONE;
			mult_q      <= tcc_pkg::MULT_W'(1);
			shift_q     <= '0;
			zero_q      <= '0;
			offset_q    <= '0;
			fix_en_q    <= 1'b0;
			fix_mult_q  <= tcc_pkg::MULT_W'(1);
			fix_shift_q <= '0;
		end else if (cfg_we) begin
			case (tcc_pkg::reg_idx_t'(cfg_index))
				tcc_pkg::REG_MODE:      mode_q      <= cfg_data[1:0];
				tcc_pkg::REG_MULT:      mult_q      <= cfg_data[tcc_pkg::MULT_W-1:0];
				tcc_pkg::REG_SHIFT:     shift_q     <= cfg_data[tcc_pkg::SHIFT_W-1:0];
				tcc_pkg::REG_ZERO:      zero_q      <= cfg_data;
				tcc_pkg::REG_OFFSET:    offset_q    <= cfg_data;
				tcc_pkg::REG_FIX_EN:    fix_en_q    <= cfg_data[0];
				tcc_pkg::REG_FIX_MULT:  fix_mult_q  <= cfg_data[tcc_pkg::MULT_W-1:0];
				tcc_pkg::REG_FIX_SHIFT: fix_shift_q <= cfg_data[tcc_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Pre stage: decode the request, remove the offset where needed and subtract the zero point to form x.
	logic               mode_ticks;
	logic               mode_on;
	tcc_pkg::flags_t    flags_c;
	logic [tcc_pkg::TS_W-1:0] a_c;
	logic               valid_s1;
	tcc_pkg::cell_t     data_s1;

	always_comb begin
		mode_on    = (mode_q != tcc_pkg::MODE_NONE);
		mode_ticks = (mode_q == tcc_pkg::MODE_TICKS);
		flags_c.use_div = ((func == tcc_pkg::FUNC_TO_EVENT) && mode_ticks) ||
			((func == tcc_pkg::FUNC_TO_REAL) && !mode_ticks && fix_en_q);
		flags_c.use_mul = ((func == tcc_pkg::FUNC_TO_NS) && mode_ticks) ||
			((func == tcc_pkg::FUNC_TO_REAL) && (mode_ticks || fix_en_q));
		flags_c.fix_sel = (func == tcc_pkg::FUNC_TO_REAL) && fix_en_q;
		flags_c.add_off = (func == tcc_pkg::FUNC_TO_EVENT) && mode_on;
		if (((func == tcc_pkg::FUNC_TO_NS) || (func == tcc_pkg::FUNC_TO_REAL)) && mode_on) begin
			a_c = timestamp_in - offset_q;
		end else begin
			a_c = timestamp_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.flags <= flags_c;
			data_s1.a     <= a_c;
			data_s1.x     <= a_c - zero_q;
			data_s1.rem   <= '0;
			data_s1.quo   <= '0;
		end
	end

	// Division chain: the quotient of x * 2^31 by the main multiplier.
	tcc_pkg::cell_t chain_d [0:tcc_pkg::DIV_STEPS];
	logic           chain_v [0:tcc_pkg::DIV_STEPS];

	assign chain_d[0] = data_s1;
	assign chain_v[0] = valid_s1;

	genvar gi;
	generate
		for (gi = 0; gi < tcc_pkg::DIV_STEPS; gi++) begin : g_cell
			tcc_div_cell #(.INDEX(gi)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.divisor (mult_q),
				.valid_i (chain_v[gi]),
				.d       (chain_d[gi]),
				.valid_o (chain_v[gi+1]),
				.q       (chain_d[gi+1])
			);
		end
	endgenerate

	// Quotient select: floor(x * 2^s / m), with the divide-by-zero case.
	tcc_pkg::cell_t                 tail;
	logic [tcc_pkg::QUO_W-1:0]      quo_sh;
	logic [tcc_pkg::TS_W-1:0]       ticks_c;
	logic                           valid_s2;
	tcc_pkg::flags_t                flags_s2;
	logic [tcc_pkg::TS_W-1:0]       v_s2;

	always_comb begin
		tail   = chain_d[tcc_pkg::DIV_STEPS];
		quo_sh = tail.quo >> (5'd31 - shift_q);
		if (mult_q == '0) begin
			ticks_c = ~(tcc_pkg::TS_W'(1) << shift_q);
		end else begin
			ticks_c = quo_sh[tcc_pkg::TS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= chain_v[tcc_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2 <= tail.flags;
			v_s2     <= tail.flags.use_div ? ticks_c : tail.a;
		end
	end

	// Multiply stage: two 32 by 32 partial products.
	logic [tcc_pkg::MULT_W-1:0]     mm_c;
	logic                           valid_s3;
	tcc_pkg::flags_t                flags_s3;
	logic [tcc_pkg::TS_W-1:0]       v_s3;
	logic [tcc_pkg::TS_W-1:0]       lo_s3;
	logic [tcc_pkg::TS_W-1:0]       hi_s3;
	logic [tcc_pkg::SHIFT_W-1:0]    sh_s3;

	assign mm_c = flags_s2.fix_sel ? fix_mult_q : mult_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s3 <= flags_s2;
			v_s3     <= v_s2;
			lo_s3    <= tcc_pkg::TS_W'(v_s2[tcc_pkg::MULT_W-1:0]) * tcc_pkg::TS_W'(mm_c);
			hi_s3    <= tcc_pkg::TS_W'(v_s2[tcc_pkg::TS_W-1:tcc_pkg::MULT_W]) *
				tcc_pkg::TS_W'(mm_c);
			sh_s3    <= flags_s2.fix_sel ? fix_shift_q : shift_q;
		end
	end

	// Shift and combine the partial products, or pass the value through when no multiply is used.
	logic [5:0]                     hi_sh_c;
	logic                           valid_s4;
	tcc_pkg::flags_t                flags_s4;
	logic [tcc_pkg::TS_W-1:0]       w_s4;

	assign hi_sh_c = 6'd32 - {1'b0, sh_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s4 <= flags_s3;
			w_s4     <= flags_s3.use_mul ? ((lo_s3 >> sh_s3) + (hi_s3 << hi_sh_c)) : v_s3;
		end
	end

	// Final add of the zero point or the offset.
	logic [tcc_pkg::TS_W-1:0]       addend_c;
	logic                           out_valid_q;
	logic [tcc_pkg::TS_W-1:0]       timestamp_out_q;

	always_comb begin
		if (flags_s4.use_mul) begin
			addend_c = zero_q;
		end else if (flags_s4.add_off) begin
			addend_c = offset_q;
		end else begin
			addend_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			timestamp_out_q <= w_s4 + addend_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign timestamp_out = timestamp_out_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(timestamp_out))
		else $error("Output changed while stalled.");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("Accepted request did not enter the pipeline.");

	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == tcc_pkg::REG_MODE)
		|=> mode_q == $past(cfg_data[1:0]))
		else $error("Mode register write lost.");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(valid_s4))
		else $error("Pipeline moved while stalled.");

endmodule
